// File: src/prc_pkg.sv
// Shared constants and types for the point record checksum block.
`timescale 1ns / 1ps

package prc_pkg;

    localparam int FLOAT_W  = 32;
    localparam int WORD_W   = 64;
    localparam int HALF_W   = WORD_W / 2;
    localparam int EXP_W    = 8;
    localparam int EXP_LSB  = 23;

    localparam int S_TDATA_W = 4 * FLOAT_W;
    localparam int M_TDATA_W = WORD_W;

    localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;
    localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;

    localparam int MIX_SH_A = 30;
    localparam int MIX_SH_B = 27;
    localparam int MIX_SH_C = 31;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [WORD_W-1:0] xy;
        logic [WORD_W-1:0] zr;
        logic              bad;
        logic              last;
    } prc_entry_t;

endpackage

// File: src/prc_front.sv
// Input stage: takes point transfers, packs the mixer words and flags bad points.
`timescale 1ns / 1ps

module prc_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [prc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            q_push,
    output prc_pkg::prc_entry_t             q_data,
    input  logic                            q_full
);

    logic [prc_pkg::FLOAT_W-1:0] x_bits;
    logic [prc_pkg::FLOAT_W-1:0] y_bits;
    logic [prc_pkg::FLOAT_W-1:0] z_bits;
    logic [prc_pkg::FLOAT_W-1:0] radius_bits;
    logic                        any_nonfinite;
    logic                        neg_radius;
    prc_pkg::prc_entry_t         entry;
    logic                        hold_valid_reg;
    prc_pkg::prc_entry_t         hold_data_reg;

    function automatic logic not_finite(input logic [prc_pkg::FLOAT_W-1:0] f);
        return &f[prc_pkg::EXP_LSB +: prc_pkg::EXP_W];
    endfunction

    assign x_bits      = s_tdata[0 +: prc_pkg::FLOAT_W];
    assign y_bits      = s_tdata[prc_pkg::FLOAT_W +: prc_pkg::FLOAT_W];
    assign z_bits      = s_tdata[2 * prc_pkg::FLOAT_W +: prc_pkg::FLOAT_W];
    assign radius_bits = s_tdata[3 * prc_pkg::FLOAT_W +: prc_pkg::FLOAT_W];

    // A negative zero radius is still a valid point.
    assign any_nonfinite = not_finite(x_bits) | not_finite(y_bits) |
                           not_finite(z_bits) | not_finite(radius_bits);
    assign neg_radius    = radius_bits[prc_pkg::FLOAT_W-1] &
                           (|radius_bits[prc_pkg::FLOAT_W-2:0]);

    always_comb begin
        entry.xy   = {x_bits, y_bits};
        entry.zr   = {z_bits, radius_bits};
        entry.bad  = any_nonfinite | neg_radius;
        entry.last = s_tlast;
    end

    assign s_tready = !hold_valid_reg || !q_full;
    assign q_push   = hold_valid_reg && !q_full;
    assign q_data   = hold_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            hold_valid_reg <= 1'b1;
            hold_data_reg  <= entry;
        end else if (q_push) begin
            hold_valid_reg <= 1'b0;
        end
    end

endmodule

// File: src/prc_queue.sv
// Two-entry queue between the input stage and the hash sequencer.
`timescale 1ns / 1ps

module prc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  prc_pkg::prc_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output prc_pkg::prc_entry_t pop_data
);

    prc_pkg::prc_entry_t              mem_reg [prc_pkg::Q_DEPTH];
    logic [prc_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [prc_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [prc_pkg::Q_CNT_W-1:0]      count_reg;

    function automatic logic [prc_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [prc_pkg::Q_PTR_W-1:0] p
    );
        if (p == prc_pkg::Q_PTR_W'(prc_pkg::Q_DEPTH - 1)) begin
            return '0;
        end
        return p + prc_pkg::Q_PTR_W'(1);
    endfunction

    assign full      = count_reg == prc_pkg::Q_CNT_W'(prc_pkg::Q_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + prc_pkg::Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - prc_pkg::Q_CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("Queue written while full.");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("Queue read while empty.");

endmodule

// File: src/prc_mix.sv
// Iterative 64-bit finalizer built around one 32x32 multiplier.
`timescale 1ns / 1ps

module prc_mix (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [prc_pkg::WORD_W-1:0]   din,
    output logic                         done,
    output logic [prc_pkg::WORD_W-1:0]   dout
);

    typedef enum logic [3:0] {
        MX_IDLE,
        MX_A0,
        MX_A1,
        MX_A2,
        MX_SB,
        MX_B0,
        MX_B1,
        MX_B2,
        MX_SC
    } mix_state_t;

    mix_state_t                     state_reg;
    logic [prc_pkg::WORD_W-1:0]     v_reg;
    logic [prc_pkg::WORD_W-1:0]     acc_reg;
    logic                           done_reg;
    logic [prc_pkg::WORD_W-1:0]     dout_reg;
    logic [prc_pkg::HALF_W-1:0]     mul_a;
    logic [prc_pkg::HALF_W-1:0]     mul_k;
    logic [prc_pkg::WORD_W-1:0]     prod;

    // The low 64 bits of a 64x64 product take three partial products:
    // low*low in full, then the low halves of the two cross terms.
    always_comb begin
        mul_a = v_reg[prc_pkg::HALF_W-1:0];
        mul_k = prc_pkg::MIX_MUL_A[prc_pkg::HALF_W-1:0];
        case (state_reg)
            MX_A0: begin
                mul_k = prc_pkg::MIX_MUL_A[prc_pkg::HALF_W-1:0];
            end
            MX_A1: begin
                mul_k = prc_pkg::MIX_MUL_A[prc_pkg::WORD_W-1:prc_pkg::HALF_W];
            end
            MX_A2: begin
                mul_a = v_reg[prc_pkg::WORD_W-1:prc_pkg::HALF_W];
                mul_k = prc_pkg::MIX_MUL_A[prc_pkg::HALF_W-1:0];
            end
            MX_B0: begin
                mul_k = prc_pkg::MIX_MUL_B[prc_pkg::HALF_W-1:0];
            end
            MX_B1: begin
                mul_k = prc_pkg::MIX_MUL_B[prc_pkg::WORD_W-1:prc_pkg::HALF_W];
            end
            MX_B2: begin
                mul_a = v_reg[prc_pkg::WORD_W-1:prc_pkg::HALF_W];
                mul_k = prc_pkg::MIX_MUL_B[prc_pkg::HALF_W-1:0];
            end
            default: begin
                mul_a = v_reg[prc_pkg::HALF_W-1:0];
                mul_k = prc_pkg::MIX_MUL_A[prc_pkg::HALF_W-1:0];
            end
        endcase
    end

    assign prod = prc_pkg::WORD_W'(mul_a) * prc_pkg::WORD_W'(mul_k);
    assign done = done_reg;
    assign dout = dout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MX_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                MX_IDLE: begin
                    if (start) begin
                        v_reg     <= din ^ (din >> prc_pkg::MIX_SH_A);
                        state_reg <= MX_A0;
                    end
                end
                MX_A0, MX_B0: begin
                    acc_reg   <= prod;
                    state_reg <= (state_reg == MX_A0) ? MX_A1 : MX_B1;
                end
                MX_A1, MX_B1: begin
                    acc_reg[prc_pkg::WORD_W-1:prc_pkg::HALF_W] <=
                        acc_reg[prc_pkg::WORD_W-1:prc_pkg::HALF_W] +
                        prod[prc_pkg::HALF_W-1:0];
                    state_reg <= (state_reg == MX_A1) ? MX_A2 : MX_B2;
                end
                MX_A2, MX_B2: begin
                    acc_reg[prc_pkg::WORD_W-1:prc_pkg::HALF_W] <=
                        acc_reg[prc_pkg::WORD_W-1:prc_pkg::HALF_W] +
                        prod[prc_pkg::HALF_W-1:0];
                    state_reg <= (state_reg == MX_A2) ? MX_SB : MX_SC;
                end
                MX_SB: begin
                    v_reg     <= acc_reg ^ (acc_reg >> prc_pkg::MIX_SH_B);
                    state_reg <= MX_B0;
                end
                MX_SC: begin
                    dout_reg  <= acc_reg ^ (acc_reg >> prc_pkg::MIX_SH_C);
                    done_reg  <= 1'b1;
                    state_reg <= MX_IDLE;
                end
                default: begin
                    state_reg <= MX_IDLE;
                end
            endcase
        end
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == MX_IDLE)
        else $error("Finalizer started while busy.");

    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("Finalizer completion held for more than one cycle.");

endmodule

// File: src/prc_back.sv
// Hash sequencer: runs the four finalizer passes, keeps running state, holds the result.
`timescale 1ns / 1ps

module prc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  prc_pkg::prc_entry_t          q_data,
    output logic                         q_pop,
    output logic                         mix_start,
    output logic [prc_pkg::WORD_W-1:0]   mix_din,
    input  logic                         mix_done,
    input  logic [prc_pkg::WORD_W-1:0]   mix_dout,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [prc_pkg::WORD_W-1:0]   out_checksum,
    output logic                         out_invalid_seen,
    output logic                         out_final
);

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_IDX,
        BK_XY,
        BK_ZR,
        BK_FIN,
        BK_OUT
    } back_state_t;

    back_state_t                    state_reg;
    prc_pkg::prc_entry_t            ent_reg;
    logic [prc_pkg::WORD_W-1:0]     idx_reg;
    logic [prc_pkg::WORD_W-1:0]     acc_reg;
    logic                           flag_reg;
    logic [prc_pkg::WORD_W-1:0]     h_reg;
    logic [prc_pkg::WORD_W-1:0]     sum_reg;
    logic                           out_valid_reg;
    logic [prc_pkg::WORD_W-1:0]     out_sum_reg;
    logic                           out_flag_reg;
    logic                           out_last_reg;
    logic                           out_load;

    always_comb begin
        mix_start = 1'b0;
        mix_din   = '0;
        case (state_reg)
            BK_IDLE: begin
                mix_start = q_valid;
                mix_din   = idx_reg + prc_pkg::GOLDEN_INC;
            end
            BK_IDX: begin
                mix_start = mix_done;
                mix_din   = ent_reg.xy;
            end
            BK_XY: begin
                mix_start = mix_done;
                mix_din   = ent_reg.zr;
            end
            BK_ZR: begin
                mix_start = mix_done;
                mix_din   = h_reg ^ mix_dout;
            end
            default: begin
                mix_start = 1'b0;
                mix_din   = '0;
            end
        endcase
    end

    assign q_pop    = (state_reg == BK_IDLE) && q_valid;
    assign out_load = (state_reg == BK_OUT) && (!out_valid_reg || out_ready);

    assign out_valid        = out_valid_reg;
    assign out_checksum     = out_sum_reg;
    assign out_invalid_seen = out_flag_reg;
    assign out_final        = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            acc_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                BK_IDLE: begin
                    if (q_valid) begin
                        ent_reg   <= q_data;
                        state_reg <= BK_IDX;
                    end
                end
                BK_IDX: begin
                    if (mix_done) begin
                        h_reg     <= mix_dout;
                        state_reg <= BK_XY;
                    end
                end
                BK_XY: begin
                    if (mix_done) begin
                        h_reg     <= h_reg ^ mix_dout;
                        state_reg <= BK_ZR;
                    end
                end
                BK_ZR: begin
                    if (mix_done) begin
                        state_reg <= BK_FIN;
                    end
                end
                BK_FIN: begin
                    if (mix_done) begin
                        sum_reg   <= acc_reg ^ mix_dout;
                        state_reg <= BK_OUT;
                    end
                end
                BK_OUT: begin
                    if (out_load) begin
                        out_valid_reg <= 1'b1;
                        out_sum_reg   <= sum_reg;
                        out_flag_reg  <= flag_reg | ent_reg.bad;
                        out_last_reg  <= ent_reg.last;
                        if (ent_reg.last) begin
                            idx_reg  <= '0;
                            acc_reg  <= '0;
                            flag_reg <= 1'b0;
                        end else begin
                            idx_reg  <= idx_reg + prc_pkg::WORD_W'(1);
                            acc_reg  <= sum_reg;
                            flag_reg <= flag_reg | ent_reg.bad;
                        end
                        state_reg <= BK_IDLE;
                    end
                end
                default: begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mix_done |-> (state_reg == BK_IDX || state_reg == BK_XY ||
                      state_reg == BK_ZR || state_reg == BK_FIN))
        else $error("Finalizer result arrived while no pass was pending.");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && ent_reg.last) |=> (idx_reg == '0 && acc_reg == '0 && !flag_reg))
        else $error("Running state not cleared after the last point.");

endmodule

// File: src/point_record_checksum.sv
// Top level of the point record checksum block.
`timescale 1ns / 1ps

// Each input transfer carries one point (x, y, z, radius as IEEE single bit
// patterns) and returns exactly one output transfer with the running XOR
// checksum, which includes this point, and a sticky flag that is set once any
// point of the set was NaN, infinite or had a negative nonzero radius. The
// transfer marked with tlast closes the set: its output covers the whole set
// and all running state clears afterwards. Points are hashed one at a time
// with four passes of a 64-bit finalizer through a single shared 32x32
// multiplier, and the sequencer takes a new point from the queue only once
// the previous one has been loaded into the output register. The input
// stage and a two-entry queue keep taking points while a hash is running,
// and the output register holds a finished result while the next point is
// already being hashed.

module point_record_checksum (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_bits, y_bits, z_bits, radius_bits
    input  logic [prc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // checksum
    output logic [prc_pkg::M_TDATA_W-1:0]   m_tdata,
    // invalid_seen
    output logic [0:0]                      m_tuser,
    output logic                            m_tlast
);

    logic                        q_push;
    prc_pkg::prc_entry_t         q_push_data;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_valid;
    prc_pkg::prc_entry_t         q_pop_data;
    logic                        mix_start;
    logic [prc_pkg::WORD_W-1:0]  mix_din;
    logic                        mix_done;
    logic [prc_pkg::WORD_W-1:0]  mix_dout;
    logic                        invalid_seen;

    prc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_data   (q_push_data),
        .q_full   (q_full)
    );

    prc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    prc_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .din     (mix_din),
        .done    (mix_done),
        .dout    (mix_dout)
    );

    prc_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_data           (q_pop_data),
        .q_pop            (q_pop),
        .mix_start        (mix_start),
        .mix_din          (mix_din),
        .mix_done         (mix_done),
        .mix_dout         (mix_dout),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_checksum     (m_tdata),
        .out_invalid_seen (invalid_seen),
        .out_final        (m_tlast)
    );

    assign m_tuser = invalid_seen;

endmodule
